### src/owbm_pkg.sv
// ----------------------------------------------------------------------------
// owbm_pkg
// Types, codes and reset values shared by the 1-Wire bus master modules.
// ----------------------------------------------------------------------------
package owbm_pkg;

	localparam int unsigned REG_W         = 16;
	localparam int unsigned CFG_IDX_W     = 3;
	localparam int unsigned IN_TDATA_W    = 16;
	localparam int unsigned IN_TUSER_W    = 2;
	localparam int unsigned OUT_TDATA_W   = 16;

	localparam int unsigned BYTE_GAP_TICKS_DEF = 32;
	localparam int unsigned COUNT_WIDTH_DEF    = 16;

	// operation selector carried with each item
	localparam logic [1:0] MODE_TICK  = 2'd0;
	localparam logic [1:0] MODE_RESET = 2'd1;
	localparam logic [1:0] MODE_WRITE = 2'd2;
	localparam logic [1:0] MODE_READ  = 2'd3;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_SAMPLE   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_RESET_RECOVERY = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SHORT          = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ONE_HIGH = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_WRITE_ZERO_LOW = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_READ_SAMPLE    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_READ_REST      = 3'd7;

	localparam logic [REG_W-1:0] RESET_LOW_DEF      = 16'd8000;
	localparam logic [REG_W-1:0] RESET_SAMPLE_DEF   = 16'd1000;
	localparam logic [REG_W-1:0] RESET_RECOVERY_DEF = 16'd10000;
	localparam logic [REG_W-1:0] SHORT_DEF          = 16'd80;
	localparam logic [REG_W-1:0] WRITE_ONE_HIGH_DEF = 16'd480;
	localparam logic [REG_W-1:0] WRITE_ZERO_LOW_DEF = 16'd1200;
	localparam logic [REG_W-1:0] READ_SAMPLE_DEF    = 16'd208;
	localparam logic [REG_W-1:0] READ_REST_DEF      = 16'd640;

	localparam logic [3:0] BITS_PER_BYTE = 4'd8;

	typedef struct packed {
		logic [REG_W-1:0] read_rest_ticks;
		logic [REG_W-1:0] read_sample_ticks;
		logic [REG_W-1:0] write_zero_low_ticks;
		logic [REG_W-1:0] write_one_high_ticks;
		logic [REG_W-1:0] short_ticks;
		logic [REG_W-1:0] reset_recovery_ticks;
		logic [REG_W-1:0] reset_sample_ticks;
		logic [REG_W-1:0] reset_low_ticks;
	} cfg_t;

	typedef struct packed {
		logic       line_level;
		logic [7:0] write_data;
		logic [1:0] mode;
	} item_t;

	typedef struct packed {
		logic       presence_level;
		logic [7:0] read_data;
		logic       done_res;
		logic       busy_res;
		logic       drive_low;
	} res_t;

	localparam int unsigned RES_W = $bits(res_t);

endpackage

### src/one_wire_bus_master.sv
// ----------------------------------------------------------------------------
// one_wire_bus_master
// 1-Wire bus master stepped by one timing tick per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Send one item on the s_t* channel for every bus tick. s_tuser carries the
//   mode: tick only, or, while idle, start a bus reset, a byte write or a byte
//   read. s_tdata carries the byte to write and the sampled line level.
//   Every item yields exactly one result item on m_t*: the line drive for that
//   tick, busy and done flags, the last read byte and the last presence level.
//   The user writes the eight timing registers on the cfg_* channel only
//   while idle; the block does not enforce it. cfg_ready is always high.
// Throughput:
//   One item per clock cycle while m_tready stays high. An accepted item is
//   held in the input register; the tick is then evaluated and its result is
//   offered on the following cycle from the output register.
// Reset:
//   arst_n clears the valid flags of both pipeline registers, puts the
//   sequencer in idle with the read byte at zero and the presence level at
//   one, and loads the default timing values.
// Stalls:
//   While m_tready is low the result holds and the input register fills; then
//   s_tready drops until the result is taken. No item is lost or repeated.
// ----------------------------------------------------------------------------
module one_wire_bus_master #(
	parameter int unsigned BYTE_GAP_TICKS = owbm_pkg::BYTE_GAP_TICKS_DEF,
	parameter int unsigned COUNT_WIDTH    = owbm_pkg::COUNT_WIDTH_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// [7:0] write_data, [8] line_level, [15:9] zero
	input  logic [owbm_pkg::IN_TDATA_W-1:0]    s_tdata,
	// [1:0] mode
	input  logic [owbm_pkg::IN_TUSER_W-1:0]    s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// [0] drive_low, [1] busy_res, [2] done_res, [10:3] read_data,
	// [11] presence_level, [15:12] zero
	output logic [owbm_pkg::OUT_TDATA_W-1:0]   m_tdata,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [owbm_pkg::REG_W-1:0]         cfg_data
);

	owbm_pkg::cfg_t  cfg;
	owbm_pkg::item_t item_s1;
	owbm_pkg::res_t  res, res_s2;
	logic            valid_s1, valid_s2, advance;

	assign advance  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.mode       <= s_tuser[1:0];
			item_s1.write_data <= s_tdata[7:0];
			item_s1.line_level <= s_tdata[8];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (m_tready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			res_s2 <= res;
	end

	owbm_cfg_regs u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	owbm_core #(
		.BYTE_GAP_TICKS (BYTE_GAP_TICKS),
		.COUNT_WIDTH    (COUNT_WIDTH)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(owbm_pkg::OUT_TDATA_W-owbm_pkg::RES_W){1'b0}}, res_s2};

	a_step_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> valid_s2)
		else $error("evaluated tick produced no result");

	a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !m_tready |-> !advance)
		else $error("result overwritten while stalled");

	a_input_held_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(item_s1))
		else $error("pending tick lost from input register");

endmodule

### src/owbm_cfg_regs.sv
// ----------------------------------------------------------------------------
// owbm_cfg_regs
// Timing register file: eight tick counts written through the config channel.
// ----------------------------------------------------------------------------
module owbm_cfg_regs (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [owbm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [owbm_pkg::REG_W-1:0]       cfg_data,
	output owbm_pkg::cfg_t                   cfg
);

	owbm_pkg::cfg_t cfg_q;

	assign cfg_ready = 1'b1;
	assign cfg       = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.reset_low_ticks      <= owbm_pkg::RESET_LOW_DEF;
			cfg_q.reset_sample_ticks   <= owbm_pkg::RESET_SAMPLE_DEF;
			cfg_q.reset_recovery_ticks <= owbm_pkg::RESET_RECOVERY_DEF;
			cfg_q.short_ticks          <= owbm_pkg::SHORT_DEF;
			cfg_q.write_one_high_ticks <= owbm_pkg::WRITE_ONE_HIGH_DEF;
			cfg_q.write_zero_low_ticks <= owbm_pkg::WRITE_ZERO_LOW_DEF;
			cfg_q.read_sample_ticks    <= owbm_pkg::READ_SAMPLE_DEF;
			cfg_q.read_rest_ticks      <= owbm_pkg::READ_REST_DEF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				owbm_pkg::REG_RESET_LOW:      cfg_q.reset_low_ticks      <= cfg_data;
				owbm_pkg::REG_RESET_SAMPLE:   cfg_q.reset_sample_ticks   <= cfg_data;
				owbm_pkg::REG_RESET_RECOVERY: cfg_q.reset_recovery_ticks <= cfg_data;
				owbm_pkg::REG_SHORT:          cfg_q.short_ticks          <= cfg_data;
				owbm_pkg::REG_WRITE_ONE_HIGH: cfg_q.write_one_high_ticks <= cfg_data;
				owbm_pkg::REG_WRITE_ZERO_LOW: cfg_q.write_zero_low_ticks <= cfg_data;
				owbm_pkg::REG_READ_SAMPLE:    cfg_q.read_sample_ticks    <= cfg_data;
				owbm_pkg::REG_READ_REST:      cfg_q.read_rest_ticks      <= cfg_data;
				default: ;
			endcase
		end
	end

endmodule

### src/owbm_core.sv
// ----------------------------------------------------------------------------
// owbm_core
// Bus sequencer: phase, tick counter, bit counter and shift register, advanced
// by one tick per item, with the per-tick line outputs.
// ----------------------------------------------------------------------------
module owbm_core #(
	parameter int unsigned BYTE_GAP_TICKS = owbm_pkg::BYTE_GAP_TICKS_DEF,
	parameter int unsigned COUNT_WIDTH    = owbm_pkg::COUNT_WIDTH_DEF
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           step,
	input  owbm_pkg::item_t item,
	input  owbm_pkg::cfg_t  cfg,
	output owbm_pkg::res_t  res
);

	typedef enum logic [11:0] {
		PH_IDLE     = 12'b0000_0000_0001,
		PH_RST_LEAD = 12'b0000_0000_0010,
		PH_RST_LOW  = 12'b0000_0000_0100,
		PH_RST_HIGH = 12'b0000_0000_1000,
		PH_RST_REC  = 12'b0000_0001_0000,
		PH_WR_LOW   = 12'b0000_0010_0000,
		PH_WR_HIGH  = 12'b0000_0100_0000,
		PH_WR_END   = 12'b0000_1000_0000,
		PH_RD_LOW   = 12'b0001_0000_0000,
		PH_RD_WAIT  = 12'b0010_0000_0000,
		PH_RD_REST  = 12'b0100_0000_0000,
		PH_GAP      = 12'b1000_0000_0000
	} phase_t;

	localparam logic [63:0] CNT_MAX64 = (64'd1 << COUNT_WIDTH) - 64'd1;
	localparam logic [63:0] GAP64     = 64'(BYTE_GAP_TICKS);
	localparam logic [COUNT_WIDTH-1:0] GAP_CNT =
		(GAP64 > CNT_MAX64) ? CNT_MAX64[COUNT_WIDTH-1:0] : GAP64[COUNT_WIDTH-1:0];
	localparam logic [COUNT_WIDTH-1:0] CNT_ONE = {{(COUNT_WIDTH-1){1'b0}}, 1'b1};

	// clip a register value to the counter range
	function automatic logic [COUNT_WIDTH-1:0] sat_dur(input logic [owbm_pkg::REG_W-1:0] dur);
		logic [63:0] wide;
		wide = {{(64-owbm_pkg::REG_W){1'b0}}, dur};
		if (wide > CNT_MAX64)
			sat_dur = CNT_MAX64[COUNT_WIDTH-1:0];
		else
			sat_dur = wide[COUNT_WIDTH-1:0];
	endfunction

	phase_t                 phase_q, ph1, phase_d;
	logic [COUNT_WIDTH-1:0] cnt_q, cnt1, cnt_d;
	logic [3:0]             bits_q, bits1, bits_d, bits_inc;
	logic [7:0]             shift_q, sh1, shift_d, sh_next;
	logic [1:0]             op_q, op1;
	logic                   pres_q, pres_d;
	logic [7:0]             rres_q, rres_d;
	logic                   drive, busy, done;

	assign bits_inc = bits1 + 4'd1;
	assign sh_next  = sh1 >> 1;

	always_comb begin
		ph1   = phase_q;
		cnt1  = cnt_q;
		bits1 = bits_q;
		sh1   = shift_q;
		op1   = op_q;
		if (phase_q == PH_IDLE && item.mode != owbm_pkg::MODE_TICK) begin
			op1   = item.mode;
			bits1 = 4'd0;
			unique case (item.mode)
				owbm_pkg::MODE_RESET: begin
					ph1  = PH_RST_LEAD;
					cnt1 = sat_dur(cfg.reset_low_ticks);
				end
				owbm_pkg::MODE_WRITE: begin
					sh1  = item.write_data;
					ph1  = PH_WR_LOW;
					cnt1 = item.write_data[0] ? sat_dur(cfg.short_ticks)
						: sat_dur(cfg.write_zero_low_ticks);
				end
				default: begin
					sh1  = 8'd0;
					ph1  = PH_RD_LOW;
					cnt1 = CNT_ONE;
				end
			endcase
		end

		phase_d = ph1;
		cnt_d   = cnt1;
		bits_d  = bits1;
		shift_d = sh1;
		pres_d  = pres_q;
		rres_d  = rres_q;
		drive   = 1'b0;
		busy    = 1'b0;
		done    = 1'b0;

		if (ph1 != PH_IDLE) begin
			busy  = 1'b1;
			drive = (ph1 == PH_RST_LOW) || (ph1 == PH_WR_LOW) || (ph1 == PH_RD_LOW);
			if (cnt1 > CNT_ONE) begin
				cnt_d = cnt1 - CNT_ONE;
			end else begin
				unique case (ph1)
					PH_RST_LEAD: begin
						phase_d = PH_RST_LOW;
						cnt_d   = sat_dur(cfg.reset_low_ticks);
					end
					PH_RST_LOW: begin
						phase_d = PH_RST_HIGH;
						cnt_d   = sat_dur(cfg.reset_sample_ticks);
					end
					PH_RST_HIGH: begin
						pres_d  = item.line_level;
						phase_d = PH_RST_REC;
						cnt_d   = sat_dur(cfg.reset_recovery_ticks);
					end
					PH_WR_LOW: begin
						if (sh1[0]) begin
							phase_d = PH_WR_HIGH;
							cnt_d   = sat_dur(cfg.write_one_high_ticks);
						end else begin
							phase_d = PH_WR_END;
							cnt_d   = sat_dur(cfg.short_ticks);
						end
					end
					PH_WR_HIGH: begin
						phase_d = PH_WR_END;
						cnt_d   = sat_dur(cfg.short_ticks);
					end
					PH_WR_END: begin
						shift_d = sh_next;
						bits_d  = bits_inc;
						if (bits_inc >= owbm_pkg::BITS_PER_BYTE) begin
							phase_d = PH_GAP;
							cnt_d   = GAP_CNT;
						end else begin
							phase_d = PH_WR_LOW;
							cnt_d   = sh_next[0] ? sat_dur(cfg.short_ticks)
								: sat_dur(cfg.write_zero_low_ticks);
						end
					end
					PH_RD_LOW: begin
						phase_d = PH_RD_WAIT;
						cnt_d   = sat_dur(cfg.read_sample_ticks);
					end
					PH_RD_WAIT: begin
						shift_d = {item.line_level | sh1[7], sh1[6:0]};
						phase_d = PH_RD_REST;
						cnt_d   = sat_dur(cfg.read_rest_ticks);
					end
					PH_RD_REST: begin
						bits_d = bits_inc;
						if (bits_inc >= owbm_pkg::BITS_PER_BYTE) begin
							phase_d = PH_GAP;
							cnt_d   = GAP_CNT;
						end else begin
							// next read slot: shift first, one tick low
							shift_d = sh_next;
							phase_d = PH_RD_LOW;
							cnt_d   = CNT_ONE;
						end
					end
					PH_GAP: begin
						if (op1 == owbm_pkg::MODE_READ)
							rres_d = sh1;
						done    = 1'b1;
						phase_d = PH_IDLE;
						cnt_d   = '0;
					end
					PH_RST_REC: begin
						done    = 1'b1;
						phase_d = PH_IDLE;
						cnt_d   = '0;
					end
					default: begin
						phase_d = PH_IDLE;
						cnt_d   = '0;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			cnt_q   <= '0;
			bits_q  <= 4'd0;
			shift_q <= 8'd0;
			op_q    <= owbm_pkg::MODE_TICK;
			pres_q  <= 1'b1;
			rres_q  <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			cnt_q   <= cnt_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
			op_q    <= op1;
			pres_q  <= pres_d;
			rres_q  <= rres_d;
		end
	end

	assign res.drive_low      = drive;
	assign res.busy_res       = busy;
	assign res.done_res       = done;
	assign res.read_data      = rres_d;
	assign res.presence_level = pres_d;

	a_done_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		step && done |=> phase_q == PH_IDLE)
		else $error("sequencer not idle after a completed operation");

	a_bit_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		bits_q <= owbm_pkg::BITS_PER_BYTE)
		else $error("bit counter ran past one byte");

	a_read_data_on_done: assert property (@(posedge clk) disable iff (!arst_n)
		step && (rres_d != rres_q) |-> done && op1 == owbm_pkg::MODE_READ)
		else $error("read result changed outside a read completion");

	a_drive_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		step && drive |=> phase_q != PH_IDLE || $past(done) || $past(cnt1 <= CNT_ONE))
		else $error("line pulled low while idle");

endmodule
